// File: design/iva_pkg.sv
// Shared types and constants for the interrupt vector allocator.
// Used by iva_ctrl, iva_datapath and the top level; depends on nothing.
package iva_pkg;

   localparam logic [1:0] MODE_RESERVE   = 2'd0;
   localparam logic [1:0] MODE_ALLOC_ONE = 2'd1;
   localparam logic [1:0] MODE_ALLOC_RUN = 2'd2;

   localparam int MODE_W    = 2;
   localparam int VEC_W     = 8;
   localparam int HANDLER_W = 64;
   localparam int LEN_W     = 9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture a new request word
      logic scan_step;     // advance the scan by one vector
      logic clear_write;   // free the vector under the index
      logic clear_next;    // move the clearing pass to the next vector
      logic reserve_write; // mark and store at the requested vector
      logic alloc_write;   // mark and store at the scanned vector
      logic run_found;     // capture the start of the found run
      logic mark_write;    // mark the vector under the index as used
      logic mark_next;     // step the marking pass back by one vector
      logic finish;        // latch the result and strobe it
      logic grant;         // result is a success
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              vec_in_range;
      logic              len_ok;
      logic              cur_free;
      logic              last_idx;
      logic              run_complete;
      logic              at_base;
   } status_type;

endpackage

// File: design/interrupt_vector_allocator.sv
// Interrupt vector allocator: reserve requests and refused checks end in the check state;
// allocate-one and run requests scan the vectors, and a granted run is then marked: the
// scan reads one used mark per cycle and the found run is marked one vector per cycle.
// One request at a time; busy drops as the result strobe rises, so the next word is
// accepted at the edge that ends it. Reset starts a clearing pass, busy high, that frees
// every vector.
module interrupt_vector_allocator #(
   parameter int VECTOR_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [iva_pkg::MODE_W-1:0]    req_mode,
   input  logic [iva_pkg::VEC_W-1:0]     req_vector_number,
   input  logic [iva_pkg::HANDLER_W-1:0] req_handler_address,
   input  logic [iva_pkg::LEN_W-1:0]     req_run_length,
   output logic                          rsp_valid,
   output logic [iva_pkg::VEC_W-1:0]     rsp_granted_vector,
   output logic                          rsp_success
);

   iva_pkg::cmd_type    cmd;
   iva_pkg::status_type status;

   iva_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   iva_datapath #(
      .VECTOR_COUNT (VECTOR_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_vector_number   (req_vector_number),
      .req_handler_address (req_handler_address),
      .req_run_length      (req_run_length),
      .rsp_valid           (rsp_valid),
      .rsp_granted_vector  (rsp_granted_vector),
      .rsp_success         (rsp_success)
   );

   // An accepted word always keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // A result word appears only once the request is done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe outside the end of a request");

   // A refused request reports vector zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_granted_vector == '0)
      else $error("refused request with nonzero vector");

endmodule

// File: design/iva_ctrl.sv
// Controller state machine of the interrupt vector allocator.
// Depends on iva_pkg; drives iva_datapath through cmd_type and reads status_type.
module iva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  iva_pkg::status_type status,
   output iva_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.last_idx) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_next = 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.mode == iva_pkg::MODE_RESERVE) begin
               cmd.finish        = 1'b1;
               cmd.grant         = status.vec_in_range;
               cmd.reserve_write = status.vec_in_range;
               state_in          = ST_IDLE;
            end else if (status.mode == iva_pkg::MODE_ALLOC_ONE) begin
               state_in = ST_SCAN;
            end else if (status.mode == iva_pkg::MODE_ALLOC_RUN && status.len_ok) begin
               state_in = ST_SCAN;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.mode == iva_pkg::MODE_ALLOC_ONE) begin
               priority if (status.cur_free) begin
                  cmd.alloc_write = 1'b1;
                  cmd.finish      = 1'b1;
                  cmd.grant       = 1'b1;
                  state_in        = ST_IDLE;
               end else if (status.last_idx) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end else begin
               priority if (status.cur_free && status.run_complete) begin
                  cmd.run_found = 1'b1;
                  state_in      = ST_MARK;
               end else if (status.last_idx) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end
         end
         ST_MARK: begin
            // The run is marked from its last vector back to its start.
            cmd.mark_write = 1'b1;
            if (status.at_base) begin
               cmd.finish = 1'b1;
               cmd.grant  = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.mark_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: design/iva_datapath.sv
// Datapath of the interrupt vector allocator: request registers, scan counters,
// used-mark memory, handler memory and result registers. Depends on iva_pkg.
module iva_datapath #(
   parameter int VECTOR_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  iva_pkg::cmd_type                  cmd,
   output iva_pkg::status_type               status,
   input  logic [iva_pkg::MODE_W-1:0]        req_mode,
   input  logic [iva_pkg::VEC_W-1:0]         req_vector_number,
   input  logic [iva_pkg::HANDLER_W-1:0]     req_handler_address,
   input  logic [iva_pkg::LEN_W-1:0]         req_run_length,
   output logic                              rsp_valid,
   output logic [iva_pkg::VEC_W-1:0]         rsp_granted_vector,
   output logic                              rsp_success
);

   localparam int IDX_W = $clog2(VECTOR_COUNT);
   localparam int CNT_W = $clog2(VECTOR_COUNT + 1);
   localparam logic [iva_pkg::LEN_W-1:0] COUNT_LEN = iva_pkg::LEN_W'(VECTOR_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VECTOR_COUNT - 1);

   logic [iva_pkg::MODE_W-1:0]    mode_ff;
   logic [iva_pkg::VEC_W-1:0]     vec_ff;
   logic [iva_pkg::HANDLER_W-1:0] handler_ff;
   logic [iva_pkg::LEN_W-1:0]     len_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              idx_in;
   logic [CNT_W-1:0]              found_ff;
   logic [IDX_W-1:0]              base_ff;
   logic                          used_rd_ff;
   logic                          rsp_valid_ff;
   logic [iva_pkg::VEC_W-1:0]     rsp_vec_ff;
   logic                          rsp_success_ff;

   logic                          used_mem [VECTOR_COUNT];
   logic [iva_pkg::HANDLER_W-1:0] handler_mem [VECTOR_COUNT];

   logic [iva_pkg::LEN_W-1:0] found_next;
   logic [IDX_W-1:0]          run_start;
   logic [IDX_W-1:0]          wr_addr;
   logic                      wr_en;
   logic                      mark_en;
   logic                      mark_data;
   logic [iva_pkg::VEC_W-1:0] result_vec;

   assign found_next = iva_pkg::LEN_W'(found_ff) + iva_pkg::LEN_W'(1);
   assign run_start  = (found_ff == '0) ? idx_ff : base_ff;
   assign wr_en      = cmd.reserve_write | cmd.alloc_write;
   assign wr_addr    = cmd.reserve_write ? vec_ff[IDX_W-1:0] : idx_ff;
   assign mark_en    = wr_en | cmd.clear_write | cmd.mark_write;
   assign mark_data  = !cmd.clear_write;

   always_comb begin
      priority if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.clear_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.mark_next) begin
         idx_in = idx_ff - IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      status.mode         = mode_ff;
      status.vec_in_range = ({1'b0, vec_ff} < COUNT_LEN);
      status.len_ok       = (len_ff != '0) && (len_ff <= COUNT_LEN);
      status.cur_free     = !used_rd_ff;
      status.last_idx     = (idx_ff == LAST_IDX);
      status.run_complete = (found_next == len_ff);
      status.at_base      = (idx_ff == base_ff);
   end

   always_comb begin
      unique case (mode_ff)
         iva_pkg::MODE_RESERVE:   result_vec = vec_ff;
         iva_pkg::MODE_ALLOC_ONE: result_vec = iva_pkg::VEC_W'(idx_ff);
         default:                 result_vec = iva_pkg::VEC_W'(base_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         vec_ff     <= req_vector_number;
         handler_ff <= req_handler_address;
         len_ff     <= req_run_length;
      end
      if (cmd.finish) begin
         rsp_vec_ff <= cmd.grant ? result_vec : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         found_ff       <= '0;
         base_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_success_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.finish;
         if (cmd.finish) begin
            rsp_success_ff <= cmd.grant;
         end
         if (cmd.load) begin
            found_ff <= '0;
         end else if (cmd.scan_step) begin
            if (status.cur_free) begin
               if (found_ff == '0) begin
                  base_ff <= idx_ff;
               end
               found_ff <= found_next[CNT_W-1:0];
            end else begin
               found_ff <= '0;
            end
         end else if (cmd.run_found) begin
            base_ff <= run_start;
         end
      end
   end

   // The mark read is addressed by the next index, so its registered data
   // always belongs to the vector under idx_ff.
   always_ff @(posedge clock) begin
      if (mark_en) begin
         used_mem[wr_addr] <= mark_data;
      end
      used_rd_ff <= used_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handler_mem[wr_addr] <= handler_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_vector = rsp_vec_ff;
   assign rsp_success        = rsp_success_ff;

   // A granted vector is marked used by the time its result is shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_success_ff |-> used_mem[rsp_vec_ff[IDX_W-1:0]])
      else $error("granted vector is not marked used");

   // Allocate-one only writes to a vector that was free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_write |-> status.cur_free)
      else $error("allocation of a used vector");

   // Marking never walks below the start of the found run.
   assert property (@(posedge clock) disable iff (reset)
      cmd.mark_write |-> idx_ff >= base_ff)
      else $error("run marking left the found run");

endmodule
